[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/ftfr_pkg.sv]
// ----------------------------------------------------------------------------
// ftfr_pkg
// Types and codes of the file transfer frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftfr_pkg;

   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_ACCEPT  = 2'd1;
   localparam logic [1:0] EV_DROP    = 2'd2;

   localparam logic [1:0] RP_NONE    = 2'd0;
   localparam logic [1:0] RP_ACK_SZ  = 2'd1;
   localparam logic [1:0] RP_ACK_END = 2'd2;
   localparam logic [1:0] RP_CANCEL  = 2'd3;

   localparam logic [7:0] TY_SIZE   = 8'h01;
   localparam logic [7:0] TY_DATA   = 8'h02;
   localparam logic [7:0] TY_END    = 8'h03;
   localparam logic [7:0] TY_CANCEL = 8'h04;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  frame_type;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
      logic [31:0] file_size_out;
      logic [31:0] received_count;
      logic        transfer_done;
      logic [1:0]  reply_code;
   } rsp_item_type;

endpackage

[hdl/ftfr_core.sv]
// ----------------------------------------------------------------------------
// ftfr_core
// Frame parser and session state; one byte per step, zero or one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftfr_core
   import ftfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   in_byte,
   output logic         has_rsp,
   output rsp_item_type rsp
);

   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_SYNC1 = 4'd1;
   localparam logic [3:0] PH_SYNC2 = 4'd2;
   localparam logic [3:0] PH_SYNC3 = 4'd3;
   localparam logic [3:0] PH_LENH  = 4'd4;
   localparam logic [3:0] PH_LENL  = 4'd5;
   localparam logic [3:0] PH_TYPE  = 4'd6;
   localparam logic [3:0] PH_DATA  = 4'd7;
   localparam logic [3:0] PH_TAIL1 = 4'd8;
   localparam logic [3:0] PH_TAIL2 = 4'd9;

   localparam logic [7:0] SYNC_B0 = 8'h0F;
   localparam logic [7:0] SYNC_B1 = 8'hF0;
   localparam logic [7:0] SYNC_B2 = 8'h00;
   localparam logic [7:0] SYNC_B3 = 8'hFF;
   localparam logic [7:0] TAIL_B0 = 8'h0D;
   localparam logic [7:0] TAIL_B1 = 8'h0A;

   logic [3:0]  phase_ff,    phase_in;
   logic [15:0] length_ff,   length_in;
   logic [7:0]  type_ff,     type_in;
   logic [15:0] count_ff,    count_in;
   logic        tail_ok_ff,  tail_ok_in;
   logic [31:0] shift_ff,    shift_in;
   logic [31:0] size_ff,     size_in;
   logic [31:0] total_ff,    total_in;
   logic        session_ff,  session_in;

   logic [3:0]  sync_fail;
   logic [32:0] sum;
   logic [31:0] sat_sum;

   assign sync_fail = (in_byte == SYNC_B0) ? PH_SYNC1 : PH_HUNT;
   assign sum       = {1'b0, total_ff} + {17'd0, length_ff};
   assign sat_sum   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      type_in    = type_ff;
      count_in   = count_ff;
      tail_ok_in = tail_ok_ff;
      shift_in   = shift_ff;
      size_in    = size_ff;
      total_in   = total_ff;
      session_in = session_ff;
      has_rsp    = 1'b0;
      rsp.event_kind    = EV_PAYLOAD;
      rsp.payload_byte  = 8'd0;
      rsp.payload_index = 16'd0;
      rsp.transfer_done = 1'b0;
      rsp.reply_code    = RP_NONE;
      case (phase_ff)
         PH_SYNC1: phase_in = (in_byte == SYNC_B1) ? PH_SYNC2 : sync_fail;
         PH_SYNC2: phase_in = (in_byte == SYNC_B2) ? PH_SYNC3 : sync_fail;
         PH_SYNC3: phase_in = (in_byte == SYNC_B3) ? PH_LENH : sync_fail;
         PH_LENH: begin
            length_in = {in_byte, 8'd0};
            phase_in  = PH_LENL;
         end
         PH_LENL: begin
            length_in = {length_ff[15:8], in_byte};
            phase_in  = PH_TYPE;
         end
         PH_TYPE: begin
            type_in  = in_byte;
            count_in = 16'd0;
            shift_in = 32'd0;
            phase_in = (length_ff == 16'd0) ? PH_TAIL1 : PH_DATA;
         end
         PH_DATA: begin
            if (count_ff[15:2] == 14'd0) begin
               case (count_ff[1:0])
                  2'd0:    shift_in[31:24] = shift_ff[31:24] | in_byte;
                  2'd1:    shift_in[23:16] = shift_ff[23:16] | in_byte;
                  2'd2:    shift_in[15:8]  = shift_ff[15:8]  | in_byte;
                  default: shift_in[7:0]   = shift_ff[7:0]   | in_byte;
               endcase
            end
            count_in = count_ff + 16'd1;
            if (count_in == length_ff) begin
               phase_in = PH_TAIL1;
            end
            has_rsp           = 1'b1;
            rsp.event_kind    = EV_PAYLOAD;
            rsp.payload_byte  = in_byte;
            rsp.payload_index = count_ff;
         end
         PH_TAIL1: begin
            tail_ok_in = (in_byte == TAIL_B0);
            phase_in   = PH_TAIL2;
         end
         PH_TAIL2: begin
            phase_in = PH_HUNT;
            has_rsp  = 1'b1;
            if (!(tail_ok_ff && in_byte == TAIL_B1)) begin
               rsp.event_kind = EV_DROP;
            end else begin
               rsp.event_kind = EV_ACCEPT;
               case (type_ff)
                  TY_SIZE: begin
                     size_in        = shift_ff;
                     total_in       = 32'd0;
                     session_in     = 1'b1;
                     rsp.reply_code = RP_ACK_SZ;
                  end
                  TY_DATA: begin
                     if (!session_ff) begin
                        rsp.reply_code = RP_CANCEL;
                     end else begin
                        total_in = sat_sum;
                        if (sat_sum >= size_ff) begin
                           rsp.transfer_done = 1'b1;
                           session_in        = 1'b0;
                        end
                     end
                  end
                  TY_END: begin
                     total_in       = size_ff;
                     session_in     = 1'b0;
                     rsp.reply_code = RP_ACK_END;
                  end
                  TY_CANCEL: session_in = 1'b0;
                  default: ;
               endcase
            end
         end
         default: phase_in = (in_byte == SYNC_B0) ? PH_SYNC1 : PH_HUNT;
      endcase
      rsp.frame_type     = type_ff;
      rsp.frame_length   = length_ff;
      rsp.file_size_out  = size_in;
      rsp.received_count = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         length_ff  <= 16'd0;
         type_ff    <= 8'd0;
         count_ff   <= 16'd0;
         tail_ok_ff <= 1'b0;
         shift_ff   <= 32'd0;
         size_ff    <= 32'd0;
         total_ff   <= 32'd0;
         session_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         count_ff   <= count_in;
         tail_ok_ff <= tail_ok_in;
         shift_ff   <= shift_in;
         size_ff    <= size_in;
         total_ff   <= total_in;
         session_ff <= session_in;
      end
   end

endmodule

[hdl/file_transfer_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// file_transfer_frame_receiver_unit
// Receives a link byte stream, hunts for the sync word 0F F0 00 FF, reads a
// big-endian 16-bit length and a type byte, emits each payload byte with its
// index, checks the 0D 0A tail and commits good frames by type (size, data,
// end, cancel), tracking file size, received count and session. One byte is
// taken per clock while no held result is stalled: a byte is registered at
// the input, parsed by the core and its result, if any, lands in the output
// register, so the sustained rate is one item per cycle; the input stalls
// only while a held result is itself stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module file_transfer_frame_receiver_unit
   import ftfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [15:0] rsp_frame_length,
   output logic [31:0] rsp_file_size_out,
   output logic [31:0] rsp_received_count,
   output logic        rsp_transfer_done,
   output logic [1:0]  rsp_reply_code
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff;
   logic         advance;
   logic         has_rsp;
   rsp_item_type rsp;

   assign advance     = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && has_rsp) || (out_valid_ff && rsp_stall);

   ftfr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .has_rsp (has_rsp),
      .rsp     (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && has_rsp) begin
         out_ff <= rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_ff.event_kind;
   assign rsp_frame_type     = out_ff.frame_type;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_index  = out_ff.payload_index;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_file_size_out  = out_ff.file_size_out;
   assign rsp_received_count = out_ff.received_count;
   assign rsp_transfer_done  = out_ff.transfer_done;
   assign rsp_reply_code     = out_ff.reply_code;

   `ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a blocked result")
   `ASSERT_IMPLY(a_non_payload_zero, clock, reset, rsp_valid && rsp_event_kind != EV_PAYLOAD, rsp_payload_byte == 8'd0 && rsp_payload_index == 16'd0, "payload fields set on a frame event")
   `ASSERT_IMPLY(a_done_count, clock, reset, rsp_valid && rsp_transfer_done, rsp_event_kind == EV_ACCEPT && rsp_received_count >= rsp_file_size_out, "transfer done without a full count")
   `ASSERT_IMPLY(a_reply_accept, clock, reset, rsp_valid && rsp_reply_code != RP_NONE, rsp_event_kind == EV_ACCEPT && !rsp_transfer_done, "reply on a frame that was not accepted")

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for file_transfer_frame_receiver_unit. Feeds a directed byte
// table with some results typed in by hand, then about 1500 random frame
// bytes with noise, broken sync and bad tails. A built-in deframer predicts
// every result item, and each result taken is checked in order against it.
// The sender idles in bursts and the receiver stalls on its own patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ftfr_pkg::*;

   localparam logic [7:0] SYNC_B0  = 8'h0F;
   localparam logic [7:0] SYNC_B1  = 8'hF0;
   localparam logic [7:0] SYNC_B2  = 8'h00;
   localparam logic [7:0] SYNC_B3  = 8'hFF;
   localparam logic [7:0] TAIL_CR  = 8'h0D;
   localparam logic [7:0] TAIL_LF  = 8'h0A;

   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int DIR_ROWS     = 31;

   localparam logic [3:0] PH_HUNT    = 4'd0;
   localparam logic [3:0] PH_SYNC_F0 = 4'd1;
   localparam logic [3:0] PH_SYNC_00 = 4'd2;
   localparam logic [3:0] PH_SYNC_FF = 4'd3;
   localparam logic [3:0] PH_LEN_HI  = 4'd4;
   localparam logic [3:0] PH_LEN_LO  = 4'd5;
   localparam logic [3:0] PH_TYPE    = 4'd6;
   localparam logic [3:0] PH_DATA    = 4'd7;
   localparam logic [3:0] PH_TAIL_CR = 4'd8;
   localparam logic [3:0] PH_TAIL_LF = 4'd9;

   typedef struct {
      logic [7:0]  din;
      bit          fixed;
      logic [1:0]  kind;
      logic [1:0]  reply;
      logic        done;
      logic [31:0] size;
      logic [31:0] count;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_frame_type;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_payload_index;
   logic [15:0] rsp_frame_length;
   logic [31:0] rsp_file_size_out;
   logic [31:0] rsp_received_count;
   logic        rsp_transfer_done;
   logic [1:0]  rsp_reply_code;

   file_transfer_frame_receiver_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_file_size_out  (rsp_file_size_out),
      .rsp_received_count (rsp_received_count),
      .rsp_transfer_done  (rsp_transfer_done),
      .rsp_reply_code     (rsp_reply_code)
   );

   // deframer state
   logic [3:0]     ph = PH_HUNT;
   logic [15:0]    frm_len = '0;
   logic [7:0]     frm_type = '0;
   logic [15:0]    data_cnt = '0;
   logic           cr_ok = 1'b0;
   logic [31:0]    size_acc = '0;
   logic [31:0]    latched_size = '0;
   logic [31:0]    byte_total = '0;
   logic           session_on = 1'b0;

   rsp_item_type frame_event_q [$];
   int           err_cnt = 0;
   int           burst_left = 0;
   int           frame_items = 0;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{SYNC_B0, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B0, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B1, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B2, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B3, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h00,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h02,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TY_SIZE, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'hAB,   1'b1, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'hCD,   1'b1, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TAIL_CR, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TAIL_LF, 1'b1, EV_ACCEPT,  RP_ACK_SZ, 1'b0, 32'hABCD0000, 32'h0},
      '{SYNC_B0, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B1, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B2, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B3, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h00,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h00,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TY_CANCEL, 1'b0, EV_PAYLOAD, RP_NONE, 1'b0, 32'h0,        32'h0},
      '{TAIL_CR, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TAIL_LF, 1'b1, EV_ACCEPT,  RP_NONE,   1'b0, 32'hABCD0000, 32'h0},
      '{SYNC_B0, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B1, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B2, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{SYNC_B3, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h00,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'h01,   1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TY_DATA, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{8'hFF,   1'b1, EV_PAYLOAD, RP_NONE,   1'b0, 32'hABCD0000, 32'h0},
      '{TAIL_CR, 1'b0, EV_PAYLOAD, RP_NONE,   1'b0, 32'h0,        32'h0},
      '{TAIL_LF, 1'b1, EV_ACCEPT,  RP_CANCEL, 1'b0, 32'hABCD0000, 32'h0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic deframe_step(input logic [7:0] b, output bit has_rsp,
                               output rsp_item_type r);
      logic [15:0] idx;
      logic [32:0] sum;
      begin
         has_rsp = 1'b0;
         r = '0;
         case (ph)
            PH_SYNC_F0: ph = (b == SYNC_B1) ? PH_SYNC_00 :
                             (b == SYNC_B0) ? PH_SYNC_F0 : PH_HUNT;
            PH_SYNC_00: ph = (b == SYNC_B2) ? PH_SYNC_FF :
                             (b == SYNC_B0) ? PH_SYNC_F0 : PH_HUNT;
            PH_SYNC_FF: ph = (b == SYNC_B3) ? PH_LEN_HI :
                             (b == SYNC_B0) ? PH_SYNC_F0 : PH_HUNT;
            PH_LEN_HI: begin
               frm_len = {b, 8'h00};
               ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               frm_len[7:0] = b;
               ph = PH_TYPE;
            end
            PH_TYPE: begin
               frm_type = b;
               data_cnt = '0;
               size_acc = '0;
               ph = (frm_len == 16'd0) ? PH_TAIL_CR : PH_DATA;
            end
            PH_DATA: begin
               idx = data_cnt;
               if (idx < 16'd4)
                  size_acc = size_acc | ({24'h0, b} << (8 * (3 - idx[1:0])));
               data_cnt = idx + 16'd1;
               if (data_cnt == frm_len)
                  ph = PH_TAIL_CR;
               has_rsp = 1'b1;
               r.event_kind = EV_PAYLOAD;
               r.payload_byte = b;
               r.payload_index = idx;
            end
            PH_TAIL_CR: begin
               cr_ok = (b == TAIL_CR);
               ph = PH_TAIL_LF;
            end
            PH_TAIL_LF: begin
               ph = PH_HUNT;
               has_rsp = 1'b1;
               if (!(cr_ok && b == TAIL_LF)) begin
                  r.event_kind = EV_DROP;
               end else begin
                  r.event_kind = EV_ACCEPT;
                  case (frm_type)
                     TY_SIZE: begin
                        latched_size = size_acc;
                        byte_total = '0;
                        session_on = 1'b1;
                        r.reply_code = RP_ACK_SZ;
                     end
                     TY_DATA: begin
                        if (!session_on) begin
                           r.reply_code = RP_CANCEL;
                        end else begin
                           sum = {1'b0, byte_total} + {17'h0, frm_len};
                           byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                           if (byte_total >= latched_size) begin
                              r.transfer_done = 1'b1;
                              session_on = 1'b0;
                           end
                        end
                     end
                     TY_END: begin
                        byte_total = latched_size;
                        session_on = 1'b0;
                        r.reply_code = RP_ACK_END;
                     end
                     TY_CANCEL: session_on = 1'b0;
                     default: ;
                  endcase
               end
            end
            default: ph = (b == SYNC_B0) ? PH_SYNC_F0 : PH_HUNT;
         endcase
         if (has_rsp) begin
            r.frame_type = frm_type;
            r.frame_length = frm_len;
            r.file_size_out = latched_size;
            r.received_count = byte_total;
         end
      end
   endtask

   // drive one byte in bursts, wait for its handshake, then predict
   task automatic feed_byte(input logic [7:0] b, output bit has_rsp,
                            output rsp_item_type r);
      int gap;
      begin
         @(negedge clock);
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_valid <= 1'b1;
         req_in_byte <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         burst_left--;
         deframe_step(b, has_rsp, r);
      end
   endtask

   task automatic send(input logic [7:0] b);
      bit           has_rsp;
      rsp_item_type r;
      begin
         feed_byte(b, has_rsp, r);
         if (has_rsp)
            frame_event_q.push_back(r);
      end
   endtask

   task automatic drain_results();
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         burst_left = 0;
         while (frame_event_q.size() != 0) @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] ftype, input int len, input int tail_mode);
      logic [31:0] size_word;
      logic [15:0] len_w;
      logic [7:0]  b;
      begin
         case ($urandom_range(0, 4))
            0, 1, 2: size_word = $urandom_range(1, 60);
            3:       size_word = $urandom_range(0, 65535);
            default: size_word = $urandom;
         endcase
         len_w = len[15:0];
         send(SYNC_B0);
         send(SYNC_B1);
         send(SYNC_B2);
         send(SYNC_B3);
         send(len_w[15:8]);
         send(len_w[7:0]);
         send(ftype);
         for (int i = 0; i < len; i++) begin
            if (ftype == TY_SIZE && i < 4)
               b = size_word[31 - 8 * i -: 8];
            else
               b = 8'($urandom_range(0, 255));
            send(b);
         end
         b = 8'($urandom_range(0, 255));
         if (tail_mode == 1) begin
            if (b == TAIL_CR)
               b = 8'h00;
            send(b);
            send(TAIL_LF);
         end else if (tail_mode == 2) begin
            if (b == TAIL_LF)
               b = 8'h00;
            send(TAIL_CR);
            send(b);
         end else begin
            send(TAIL_CR);
            send(TAIL_LF);
         end
         frame_items += len + 9;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_event_kind, rsp_frame_type, rsp_payload_byte, rsp_payload_index,
                rsp_frame_length, rsp_file_size_out, rsp_received_count,
                rsp_transfer_done, rsp_reply_code};
         if (frame_event_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
               $display("%0t: result with none expected: kind=%0d type=%h idx=%0d",
                        $time, got.event_kind, got.frame_type, got.payload_index);
         end else begin
            want = frame_event_q.pop_front();
            if (got !== want) begin
               err_cnt++;
               if (err_cnt <= 10) begin
                  $display("%0t: mismatch kind/type/byte/idx/len/size/count/done/reply", $time);
                  $display("  exp %0d %h %h %0d %0d %h %h %b %0d", want.event_kind,
                           want.frame_type, want.payload_byte, want.payload_index,
                           want.frame_length, want.file_size_out, want.received_count,
                           want.transfer_done, want.reply_code);
                  $display("  got %0d %h %h %0d %0d %h %h %b %0d", got.event_kind,
                           got.frame_type, got.payload_byte, got.payload_index,
                           got.frame_length, got.file_size_out, got.received_count,
                           got.transfer_done, got.reply_code);
               end
            end
         end
      end
   end

   // receiver stall patterns
   initial begin
      int mode;
      int span;
      int cyc;
      rsp_stall = 1'b0;
      cyc = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            cyc++;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ((cyc % 8) < 5);
            endcase
         end
      end
   end

   // watchdog
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      bit           has_rsp;
      rsp_item_type r;
      int           sel;
      int           len;
      int           n;
      logic [7:0]   ftype;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIR_ROWS; k++) begin
         feed_byte(dir_tab[k].din, has_rsp, r);
         if (dir_tab[k].fixed) begin
            r.event_kind = dir_tab[k].kind;
            r.reply_code = dir_tab[k].reply;
            r.transfer_done = dir_tab[k].done;
            r.file_size_out = dir_tab[k].size;
            r.received_count = dir_tab[k].count;
            has_rsp = 1'b1;
         end
         if (has_rsp)
            frame_event_q.push_back(r);
      end
      drain_results();

      while (frame_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 78) begin
            n = $urandom_range(0, 99);
            ftype = (n < 20) ? TY_SIZE : (n < 65) ? TY_DATA : (n < 75) ? TY_END :
                    (n < 85) ? TY_CANCEL : 8'($urandom_range(0, 255));
            if (ftype == TY_SIZE) begin
               n = $urandom_range(0, 9);
               len = (n < 6) ? 4 : (n < 8) ? $urandom_range(0, 3) : $urandom_range(5, 9);
            end else begin
               n = $urandom_range(0, 99);
               len = (n < 85) ? $urandom_range(0, 12) :
                     (n < 97) ? $urandom_range(13, 40) : $urandom_range(250, 300);
            end
            n = $urandom_range(0, 9);
            send_frame(ftype, len, (n < 8) ? 0 : n - 7);
         end else if (sel < 88) begin
            n = $urandom_range(1, 6);
            repeat (n)
               send(($urandom_range(0, 3) == 0) ? SYNC_B0 : 8'($urandom_range(0, 255)));
         end else if (sel < 97) begin
            send(SYNC_B0);
            if ($urandom_range(0, 1)) begin
               send(SYNC_B1);
               if ($urandom_range(0, 1))
                  send(SYNC_B2);
            end
            send(8'($urandom_range(0, 255)));
         end else begin
            drain_results();
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/ftfr_pkg.sv
hdl/ftfr_core.sv
hdl/file_transfer_frame_receiver_unit.sv
bench/tb.sv
